// ===== sv/mmbd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mmbd_pkg
// shared constants, codes and request type for the memory map bus decoder
// ----------------------------------------------------------------------------
package mmbd_pkg;

  // store sizes in bytes (powers of two, but for the video ram)
  localparam int BIOS_BYTES     = 16384;
  localparam int SLOW_RAM_BYTES = 262144;
  localparam int FAST_RAM_BYTES = 32768;
  localparam int ROM_BYTES      = 33554432;
  localparam int PAL_BYTES      = 1024;
  localparam int VID_BYTES      = 98304;
  localparam int OBJ_BYTES      = 1024;

  // work memory layout in 32-bit words: all writable and small stores share one ram
  localparam int SLOW_BASE = 0;
  localparam int VID_BASE  = SLOW_BASE + SLOW_RAM_BYTES / 4;
  localparam int FAST_BASE = VID_BASE + VID_BYTES / 4;
  localparam int BIOS_BASE = FAST_BASE + FAST_RAM_BYTES / 4;
  localparam int PAL_BASE  = BIOS_BASE + BIOS_BYTES / 4;
  localparam int OBJ_BASE  = PAL_BASE + PAL_BYTES / 4;
  localparam int WRK_WORDS = OBJ_BASE + OBJ_BYTES / 4;
  localparam int WRK_AW    = $clog2(WRK_WORDS);

  localparam int ROM_WORDS = ROM_BYTES / 4;
  localparam int ROM_AW    = $clog2(ROM_WORDS);

  // offset masks per region
  localparam logic [31:0] BIOS_OFS_MASK = 32'h0000_3fff & (BIOS_BYTES - 1);
  localparam logic [31:0] SLOW_OFS_MASK = 32'h0003_ffff & (SLOW_RAM_BYTES - 1);
  localparam logic [31:0] FAST_OFS_MASK = 32'h0000_7fff & (FAST_RAM_BYTES - 1);
  localparam logic [31:0] PAL_OFS_MASK  = 32'h0000_03ff;
  localparam logic [31:0] VID_OFS_MASK  = 32'h0001_ffff;
  localparam logic [31:0] VID_OFS_LIMIT = 32'h0001_7fff;
  localparam logic [31:0] ROM_LIM_MASK  = ROM_BYTES - 1;
  localparam logic [31:0] ROM_LOAD_MASK = 32'h01ff_ffff & (ROM_BYTES - 1);

  // configuration register
  localparam int              ROM_MASK_W     = 25;
  localparam logic [24:0]     ROM_MASK_RESET = 25'h1ff_ffff;
  localparam int              CFG_AW         = 3;
  localparam logic            CFG_IDX_ROM_MASK = 1'b0;

  // opcodes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;

  // access sizes (anything else is a word)
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;

  // region codes, address bits 27:24
  localparam logic [3:0] RGN_BIOS     = 4'h0;
  localparam logic [3:0] RGN_SLOW     = 4'h2;
  localparam logic [3:0] RGN_FAST     = 4'h3;
  localparam logic [3:0] RGN_IO       = 4'h4;
  localparam logic [3:0] RGN_PAL      = 4'h5;
  localparam logic [3:0] RGN_VID      = 4'h6;
  localparam logic [3:0] RGN_OBJ      = 4'h7;
  localparam logic [3:0] RGN_ROM_LO   = 4'h8;
  localparam logic [3:0] RGN_ROM_HI   = 4'hd;

  // decoded request: memory commands plus what the result stage needs
  typedef struct packed {
    logic              wrk_we;
    logic              wrk_re;
    logic [WRK_AW-1:0] wrk_addr;
    logic              rom_we;
    logic              rom_re;
    logic [ROM_AW-1:0] rom_addr;
    logic [3:0]        be;
    logic [31:0]       wdata;
    logic              rd;
    logic              rom_sel;
    logic [1:0]        lane;
    logic [1:0]        size;
    logic              io_fwd;
    logic [31:0]       io_addr;
    logic [31:0]       io_wdata;
  } mmbd_req_t;

endpackage : mmbd_pkg
`default_nettype wire

// ===== sv/mmbd_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mmbd_ram
// single-port synchronous ram with byte write enables and registered read
// ----------------------------------------------------------------------------
module mmbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [WIDTH/8-1:0]         be,
  input  wire logic                       re,
  input  wire logic [$clog2(DEPTH)-1:0]   addr,
  input  wire logic [WIDTH-1:0]           wdata,
  output logic      [WIDTH-1:0]           rdata
);

  localparam int NB = WIDTH / 8;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      for (int b = 0; b < NB; b++) begin
        if (be[b]) begin
          mem[addr][8*b +: 8] <= wdata[8*b +: 8];
        end
      end
    end
    // read data holds until the next read
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule : mmbd_ram
`default_nettype wire

// ===== sv/mmbd_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mmbd_decode
// size alignment, region decode, offset masking and byte lane steering
// ----------------------------------------------------------------------------
module mmbd_decode (
  input  wire logic                           en,
  input  wire logic [1:0]                     opcode,
  input  wire logic [31:0]                    address,
  input  wire logic [1:0]                     access_size,
  input  wire logic [31:0]                    write_data,
  input  wire logic [mmbd_pkg::ROM_MASK_W-1:0] rom_mask,
  output mmbd_pkg::mmbd_req_t                 req
);
  import mmbd_pkg::*;

  logic [31:0] al;
  logic [31:0] dm;
  logic [31:0] wd;
  logic [3:0]  region;
  logic [31:0] off;
  logic [31:0] wbase;
  logic        map_ok;
  logic        wr_ok;
  logic        dup;
  logic        rom_sel;
  logic        is_rw;
  logic        is_io;
  logic        ld_wrk;
  logic        ld_rom;
  logic [1:0]  lane;
  logic [3:0]  be;

  always_comb begin
    // align and trim data to the access size
    case (access_size)
      SZ_BYTE: begin
        al = address;
        dm = {24'b0, write_data[7:0]};
      end
      SZ_HALF: begin
        al = {address[31:1], 1'b0};
        dm = {16'b0, write_data[15:0]};
      end
      default: begin
        al = {address[31:2], 2'b00};
        dm = write_data;
      end
    endcase
    region = al[27:24];

    map_ok  = 1'b0;
    wr_ok   = 1'b0;
    dup     = 1'b0;
    rom_sel = 1'b0;
    off     = '0;
    wbase   = '0;
    case (region)
      RGN_BIOS: begin
        map_ok = 1'b1;
        off    = al & BIOS_OFS_MASK;
        wbase  = 32'(BIOS_BASE);
      end
      RGN_SLOW: begin
        map_ok = 1'b1;
        wr_ok  = 1'b1;
        off    = al & SLOW_OFS_MASK;
        wbase  = 32'(SLOW_BASE);
      end
      RGN_FAST: begin
        map_ok = 1'b1;
        wr_ok  = 1'b1;
        off    = al & FAST_OFS_MASK;
        wbase  = 32'(FAST_BASE);
      end
      RGN_PAL: begin
        map_ok = 1'b1;
        wr_ok  = 1'b1;
        dup    = 1'b1;
        off    = al & PAL_OFS_MASK;
        wbase  = 32'(PAL_BASE);
      end
      RGN_VID: begin
        // upper part of the window is a hole
        off    = al & VID_OFS_MASK;
        map_ok = (off <= VID_OFS_LIMIT);
        wr_ok  = (off <= VID_OFS_LIMIT);
        dup    = 1'b1;
        wbase  = 32'(VID_BASE);
      end
      RGN_OBJ: begin
        map_ok = 1'b1;
        wr_ok  = 1'b1;
        dup    = 1'b1;
        off    = al & PAL_OFS_MASK;
        wbase  = 32'(OBJ_BASE);
      end
      default: begin
        if (region inside {[RGN_ROM_LO:RGN_ROM_HI]}) begin
          map_ok  = 1'b1;
          rom_sel = 1'b1;
          off     = al & {7'b0, rom_mask} & ROM_LIM_MASK;
        end
      end
    endcase

    // image load: raw byte address, size ignored
    ld_wrk = (opcode == OP_LOAD) && (address[27:24] == RGN_BIOS);
    ld_rom = (opcode == OP_LOAD) && (address[27:24] inside {[RGN_ROM_LO:RGN_ROM_HI]});
    if (ld_wrk) begin
      off     = address & BIOS_OFS_MASK;
      wbase   = 32'(BIOS_BASE);
      rom_sel = 1'b0;
    end else if (ld_rom) begin
      off     = address & ROM_LOAD_MASK;
      rom_sel = 1'b1;
    end

    // byte lanes come from the masked offset, the rom mask may clear low bits
    lane = off[1:0];
    if (opcode == OP_LOAD) begin
      be = 4'b0001 << lane;
      wd = {4{write_data[7:0]}};
    end else begin
      case (access_size)
        SZ_BYTE: begin
          be = dup ? (4'b0011 << {lane[1], 1'b0}) : (4'b0001 << lane);
          wd = {4{write_data[7:0]}};
        end
        SZ_HALF: begin
          be = 4'b0011 << {lane[1], 1'b0};
          wd = {2{write_data[15:0]}};
        end
        default: begin
          be = 4'b1111;
          wd = write_data;
        end
      endcase
    end

    is_rw = (opcode == OP_READ) || (opcode == OP_WRITE);
    is_io = is_rw && (region == RGN_IO);

    req.rd       = (opcode == OP_READ) && map_ok;
    req.rom_sel  = rom_sel;
    req.lane     = lane;
    req.size     = access_size;
    req.wrk_re   = en && req.rd && !rom_sel;
    req.rom_re   = en && req.rd && rom_sel;
    req.wrk_we   = en && (((opcode == OP_WRITE) && wr_ok) || ld_wrk);
    req.rom_we   = en && ld_rom;
    req.wrk_addr = WRK_AW'(wbase + (off >> 2));
    req.rom_addr = ROM_AW'(off >> 2);
    req.be       = be;
    req.wdata    = wd;
    req.io_fwd   = is_io;
    req.io_addr  = is_io ? al : 32'b0;
    req.io_wdata = (is_io && (opcode == OP_WRITE)) ? dm : 32'b0;
  end

endmodule : mmbd_decode
`default_nettype wire

// ===== sv/memory_map_bus_decoder_core.sv =====
`default_nettype none
// path: an accepted request passes the memory stage, then the output register
// throughput: one request per cycle while results are taken; a stalled result
//   holds the memory stage, so at most two requests are in flight
// reset: synchronous active-low rst_n clears the pipeline valids and sets
//   rom_mask_r to all ones; memory contents are not cleared (no sweep)
// ----------------------------------------------------------------------------
// memory_map_bus_decoder_core
// bus address decoder with attached bios, ram, video and rom storage
// ----------------------------------------------------------------------------
module memory_map_bus_decoder_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // request channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_opcode,
  input  wire logic [31:0]                   in_address,
  input  wire logic [1:0]                    in_access_size,
  input  wire logic [31:0]                   in_write_data,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [31:0]                        out_read_data,
  output logic                               out_io_forward,
  output logic [31:0]                        out_io_address,
  output logic [31:0]                        out_io_write_data,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mmbd_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import mmbd_pkg::*;

  // configuration register
  logic [ROM_MASK_W-1:0] rom_mask_r, rom_mask_nxt;
  logic                  cfg_wr;

  // memory stage: request waiting on ram read data
  logic      s1_valid_r, s1_valid_nxt;
  mmbd_req_t s1_req_r, s1_req_nxt;
  logic      s1_adv;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_rd_r, out_rd_nxt;
  logic        out_io_r, out_io_nxt;
  logic [31:0] out_ioa_r, out_ioa_nxt;
  logic [31:0] out_iowd_r, out_iowd_nxt;

  logic        accept;
  mmbd_req_t   req;
  logic [31:0] wrk_rdata;
  logic [31:0] rom_rdata;
  logic [31:0] rword;
  logic [31:0] rd_fmt;

  // apb: pready is held high, one register at index zero
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_IDX_ROM_MASK);
  assign prdata = (paddr[2] == CFG_IDX_ROM_MASK) ? {7'b0, rom_mask_r} : 32'b0;
  assign rom_mask_nxt = cfg_wr ? pwdata[ROM_MASK_W-1:0] : rom_mask_r;

  // the memory stage moves on when the output register is free or being drained
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;

  // decode straight from the request ports; memories are hit at the accept edge
  mmbd_decode u_decode (
    .en          (accept),
    .opcode      (in_opcode),
    .address     (in_address),
    .access_size (in_access_size),
    .write_data  (in_write_data),
    .rom_mask    (rom_mask_r),
    .req         (req)
  );

  // bios, slow, fast, palette, video and object ram packed into one word ram
  mmbd_ram #(
    .WIDTH (32),
    .DEPTH (WRK_WORDS)
  ) u_wrk_ram (
    .clk   (clk),
    .we    (req.wrk_we),
    .be    (req.be),
    .re    (req.wrk_re),
    .addr  (req.wrk_addr),
    .wdata (req.wdata),
    .rdata (wrk_rdata)
  );

  // cartridge rom image, filled by load requests
  mmbd_ram #(
    .WIDTH (32),
    .DEPTH (ROM_WORDS)
  ) u_rom_ram (
    .clk   (clk),
    .we    (req.rom_we),
    .be    (req.be),
    .re    (req.rom_re),
    .addr  (req.rom_addr),
    .wdata (req.wdata),
    .rdata (rom_rdata)
  );

  // pick the bytes of the access out of the read word, zero-extended
  always_comb begin
    rword = s1_req_r.rom_sel ? rom_rdata : wrk_rdata;
    case (s1_req_r.size)
      SZ_BYTE: rd_fmt = {24'b0, rword[{s1_req_r.lane, 3'b000} +: 8]};
      SZ_HALF: rd_fmt = {16'b0, rword[{s1_req_r.lane[1], 4'b0000} +: 16]};
      default: rd_fmt = rword;
    endcase
    // writes, loads, forwarded and unmapped accesses answer zero
    if (!s1_req_r.rd) begin
      rd_fmt = 32'b0;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_req_nxt   = s1_req_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
      s1_req_nxt   = req;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    out_rd_nxt    = out_rd_r;
    out_io_nxt    = out_io_r;
    out_ioa_nxt   = out_ioa_r;
    out_iowd_nxt  = out_iowd_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
      out_rd_nxt    = rd_fmt;
      out_io_nxt    = s1_req_r.io_fwd;
      out_ioa_nxt   = s1_req_r.io_addr;
      out_iowd_nxt  = s1_req_r.io_wdata;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_mask_r  <= ROM_MASK_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rom_mask_r  <= rom_mask_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    s1_req_r   <= s1_req_nxt;
    out_rd_r   <= out_rd_nxt;
    out_io_r   <= out_io_nxt;
    out_ioa_r  <= out_ioa_nxt;
    out_iowd_r <= out_iowd_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = out_rd_r;
  assign out_io_forward    = out_io_r;
  assign out_io_address    = out_ioa_r;
  assign out_io_write_data = out_iowd_r;

endmodule : memory_map_bus_decoder_core
`default_nettype wire

// ===== verif/mmbd_access_checker.sv =====
// ----------------------------------------------------------------------------
// mmbd_access_checker
// watches the request, result and register ports of the bus decoder, keeps
// its own copy of every store and the rom window, and compares each result
// with the oldest expected reply
// ----------------------------------------------------------------------------
module mmbd_access_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic                        in_ready,
  input  wire logic [1:0]                  in_opcode,
  input  wire logic [31:0]                 in_address,
  input  wire logic [1:0]                  in_access_size,
  input  wire logic [31:0]                 in_write_data,
  input  wire logic                        out_valid,
  input  wire logic                        out_ready,
  input  wire logic [31:0]                 out_read_data,
  input  wire logic                        out_io_forward,
  input  wire logic [31:0]                 out_io_address,
  input  wire logic [31:0]                 out_io_write_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mmbd_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  input  wire logic                        pready,
  output int                               failures,
  output int                               outstanding
);
  import mmbd_pkg::*;

  localparam logic [CFG_AW-1:0] ROM_MASK_ADDR = CFG_AW'(4 * CFG_IDX_ROM_MASK);

  typedef enum logic [3:0] {
    ST_NONE, ST_BIOS, ST_SLOW, ST_FAST, ST_PAL, ST_VID, ST_OBJ, ST_ROM
  } store_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] address;
    logic [1:0]  size;
    logic [31:0] wdata;
  } bus_access_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        io_forward;
    logic [31:0] io_address;
    logic [31:0] io_write_data;
  } bus_reply_t;

  // sparse byte image of all stores, keyed by store and byte index
  logic [7:0]  byte_mem [bit [31:0]];
  logic [24:0] window_mask = ROM_MASK_RESET;
  bus_reply_t  expected_replies [$];

  initial failures = 0;
  initial outstanding = 0;

  function automatic bit [31:0] mem_key(store_t st, logic [31:0] idx);
    return {st, idx[27:0]};
  endfunction

  function automatic bus_reply_t decode_access(bus_access_t acc);
    bus_reply_t  rep;
    logic [31:0] addr;
    logic [31:0] data;
    logic [31:0] base;
    logic [31:0] depth;
    logic [31:0] rd;
    logic [31:0] half;
    logic [3:0]  rgn;
    bit [31:0]   key;
    int          nbytes;
    store_t      st;
    rep = '0;
    addr = acc.address;
    data = acc.wdata;
    rgn = addr[27:24];
    base = 0;
    depth = 1;
    rd = 0;
    st = ST_NONE;
    // image loads ignore the size and store the low byte
    if (acc.opcode == OP_LOAD) begin
      if (rgn == RGN_BIOS)
        byte_mem[mem_key(ST_BIOS, (addr & BIOS_OFS_MASK) % BIOS_BYTES)] = data[7:0];
      else if (rgn >= RGN_ROM_LO && rgn <= RGN_ROM_HI)
        byte_mem[mem_key(ST_ROM, (addr & ROM_LOAD_MASK) % ROM_BYTES)] = data[7:0];
      return rep;
    end
    if (acc.opcode != OP_READ && acc.opcode != OP_WRITE) return rep;
    case (acc.size)
      SZ_BYTE: begin
        nbytes = 1;
        data &= 32'h0000_00ff;
      end
      SZ_HALF: begin
        nbytes = 2;
        addr[0] = 1'b0;
        data &= 32'h0000_ffff;
      end
      default: begin
        nbytes = 4;
        addr[1:0] = 2'b00;
      end
    endcase
    if (rgn == RGN_IO) begin
      rep.io_forward = 1'b1;
      rep.io_address = addr;
      rep.io_write_data = (acc.opcode == OP_WRITE) ? data : 32'h0;
      return rep;
    end
    case (rgn)
      RGN_BIOS: begin
        st = ST_BIOS;
        base = (addr & BIOS_OFS_MASK) % BIOS_BYTES;
        depth = BIOS_BYTES;
      end
      RGN_SLOW: begin
        st = ST_SLOW;
        base = (addr & SLOW_OFS_MASK) % SLOW_RAM_BYTES;
        depth = SLOW_RAM_BYTES;
      end
      RGN_FAST: begin
        st = ST_FAST;
        base = (addr & FAST_OFS_MASK) % FAST_RAM_BYTES;
        depth = FAST_RAM_BYTES;
      end
      RGN_PAL: begin
        st = ST_PAL;
        base = addr & PAL_OFS_MASK;
        depth = PAL_BYTES;
      end
      RGN_VID: begin
        if ((addr & VID_OFS_MASK) <= VID_OFS_LIMIT) begin
          st = ST_VID;
          base = addr & VID_OFS_MASK;
          depth = VID_BYTES;
        end
      end
      RGN_OBJ: begin
        st = ST_OBJ;
        base = addr & PAL_OFS_MASK;
        depth = OBJ_BYTES;
      end
      default: begin
        if (rgn >= RGN_ROM_LO && rgn <= RGN_ROM_HI) begin
          st = ST_ROM;
          base = (addr & {7'd0, window_mask}) % ROM_BYTES;
          depth = ROM_BYTES;
        end
      end
    endcase
    if (acc.opcode == OP_READ) begin
      if (st != ST_NONE) begin
        for (int i = 0; i < nbytes; i++) begin
          key = mem_key(st, (base + i) % depth);
          if (byte_mem.exists(key)) rd |= 32'(byte_mem[key]) << (8 * i);
        end
      end
      rep.read_data = rd;
      return rep;
    end
    // writes to read-only or silent regions vanish
    if (st == ST_NONE || st == ST_BIOS || st == ST_ROM) return rep;
    if (nbytes == 1 && (st == ST_PAL || st == ST_VID || st == ST_OBJ)) begin
      half = base & 32'hffff_fffe;
      byte_mem[mem_key(st, half % depth)] = data[7:0];
      byte_mem[mem_key(st, (half + 1) % depth)] = data[7:0];
      return rep;
    end
    for (int i = 0; i < nbytes; i++)
      byte_mem[mem_key(st, (base + i) % depth)] = data[8*i +: 8];
    return rep;
  endfunction

  function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    bus_access_t acc;
    bus_reply_t  want;
    if (!rst_n) begin
      window_mask = ROM_MASK_RESET;
      expected_replies.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ROM_MASK_ADDR)
        window_mask = pwdata[24:0];
      // results first, so a request taken at this edge is never matched early
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: result with no request waiting, expected none, actual %h %b %h %h",
                   $time, out_read_data, out_io_forward, out_io_address, out_io_write_data);
          failures++;
        end else begin
          want = expected_replies.pop_front();
          compare_field("read_data", want.read_data, out_read_data);
          compare_field("io_forward", 32'(want.io_forward), 32'(out_io_forward));
          compare_field("io_address", want.io_address, out_io_address);
          compare_field("io_write_data", want.io_write_data, out_io_write_data);
        end
      end
      if (in_valid && in_ready) begin
        acc.opcode = in_opcode;
        acc.address = in_address;
        acc.size = in_access_size;
        acc.wdata = in_write_data;
        expected_replies.push_back(decode_access(acc));
      end
    end
    outstanding <= expected_replies.size();
  end

endmodule : mmbd_access_checker

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives bus requests and rom window settings into the decoder in phases of
// differing back-pressure; reads only touch bytes that were written or loaded
// ----------------------------------------------------------------------------
module tb_top;
  import mmbd_pkg::*;

  // codes the package leaves unnamed
  localparam logic [1:0] OP_NOP      = 2'd3;
  localparam logic [1:0] SZ_WORD     = 2'd2;
  localparam logic [1:0] SZ_WIDE     = 2'd3;
  localparam logic [3:0] RGN_UNUSED  = 4'h1;
  localparam logic [3:0] RGN_SRAM_LO = 4'he;
  localparam logic [3:0] RGN_SRAM_HI = 4'hf;

  localparam logic [CFG_AW-1:0] ROM_MASK_ADDR = CFG_AW'(4 * CFG_IDX_ROM_MASK);

  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 115;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 1000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_opcode = '0;
  logic [31:0]       in_address = '0;
  logic [1:0]        in_access_size = '0;
  logic [31:0]       in_write_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [31:0]       out_read_data;
  logic              out_io_forward;
  logic [31:0]       out_io_address;
  logic [31:0]       out_io_write_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  int failures;
  int outstanding;

  // back-pressure settings, in percent of cycles
  int send_idle = 0;
  int stall_pct = 0;
  int phase_items = 0;
  int quiet_cycles = 0;

  // stimulus bookkeeping: words known to hold data, and the current rom window
  logic [31:0] ram_words [$];
  logic [24:0] rom_words [$];
  logic [24:0] rom_window = ROM_MASK_RESET;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  memory_map_bus_decoder_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_address        (in_address),
    .in_access_size    (in_access_size),
    .in_write_data     (in_write_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_data     (out_read_data),
    .out_io_forward    (out_io_forward),
    .out_io_address    (out_io_address),
    .out_io_write_data (out_io_write_data),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  mmbd_access_checker access_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_address        (in_address),
    .in_access_size    (in_access_size),
    .in_write_data     (in_write_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_data     (out_read_data),
    .out_io_forward    (out_io_forward),
    .out_io_address    (out_io_address),
    .out_io_write_data (out_io_write_data),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .pready            (pready),
    .failures          (failures),
    .outstanding       (outstanding)
  );

  // result side back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog: too long without any request or result moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offset bits that select a byte inside a ram or bios region
  function automatic logic [31:0] offset_mask(logic [3:0] rgn);
    case (rgn)
      RGN_BIOS: return BIOS_OFS_MASK;
      RGN_SLOW: return SLOW_OFS_MASK;
      RGN_FAST: return FAST_OFS_MASK;
      RGN_VID:  return VID_OFS_MASK;
      default:  return PAL_OFS_MASK;
    endcase
  endfunction

  // same word seen through a random mirror and a random byte lane
  function automatic logic [31:0] alias_of(logic [31:0] canon);
    logic [31:0] keep;
    keep = 32'h0f00_0000 | offset_mask(canon[27:24]);
    return (canon & keep) | ($urandom & ~keep) | 32'($urandom_range(3));
  endfunction

  // rom read that lands on a loaded word under the current window
  function automatic logic [31:0] rom_alias(logic [24:0] word_ofs);
    logic [24:0] low;
    low = word_ofs | (25'($urandom) & ~rom_window) | 25'($urandom_range(3));
    return {4'($urandom), 3'($urandom_range(6, 4)), low};
  endfunction

  function automatic logic [31:0] random_ram_word();
    logic [3:0]  rgn;
    logic [31:0] ofs;
    case ($urandom_range(4))
      0:       rgn = RGN_SLOW;
      1:       rgn = RGN_FAST;
      2:       rgn = RGN_PAL;
      3:       rgn = RGN_VID;
      default: rgn = RGN_OBJ;
    endcase
    ofs = (rgn == RGN_VID) ? 32'($urandom_range(VID_OFS_LIMIT)) : $urandom & offset_mask(rgn);
    return {4'h0, rgn, ofs[23:0] & 24'hff_fffc};
  endfunction

  // regions that answer zero: unused, sram and the video ram hole
  function automatic logic [31:0] quiet_address();
    case ($urandom_range(3))
      0:       return {4'($urandom), RGN_UNUSED, 24'($urandom)};
      1:       return {4'($urandom), RGN_SRAM_LO, 24'($urandom)};
      2:       return {4'($urandom), RGN_SRAM_HI, 24'($urandom)};
      default: return {4'($urandom), RGN_VID, 7'($urandom), 17'($urandom_range(17'h1ffff, 17'h18000))};
    endcase
  endfunction

  // one request: random idle gap, then hold valid until taken
  task automatic issue(input logic [1:0] op, input logic [31:0] addr,
                       input logic [1:0] size, input logic [31:0] data);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_address <= addr;
    in_access_size <= size;
    in_write_data <= data;
    do @(posedge clk); while (!in_ready);
    phase_items++;
  endtask

  task automatic store_word(input logic [31:0] canon, input logic [31:0] data);
    issue(OP_WRITE, alias_of(canon), $urandom_range(1) ? SZ_WORD : SZ_WIDE, data);
    ram_words.push_back(canon);
  endtask

  // four byte loads fill one bios word
  task automatic load_bios_word(input logic [13:0] ofs, input logic [31:0] data);
    for (int i = 0; i < 4; i++)
      issue(OP_LOAD, {4'($urandom), RGN_BIOS, 10'($urandom), ofs | 14'(i)},
            2'($urandom), {24'($urandom), data[8*i +: 8]});
    ram_words.push_back({4'h0, RGN_BIOS, 10'h0, ofs});
  endtask

  task automatic load_rom_word(input logic [24:0] ofs, input logic [31:0] data);
    for (int i = 0; i < 4; i++)
      issue(OP_LOAD, {4'($urandom), 3'($urandom_range(6, 4)), ofs | 25'(i)},
            2'($urandom), {24'($urandom), data[8*i +: 8]});
    rom_words.push_back(ofs);
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 25) begin
      store_word(random_ram_word(), $urandom);
    end else if (pick < 35) begin
      // any size anywhere: also hits read-only and silent regions
      issue(OP_WRITE, $urandom, 2'($urandom), $urandom);
    end else if (pick < 42) begin
      load_rom_word(25'($urandom) & rom_window & 25'h1ff_fffc, $urandom);
    end else if (pick < 46) begin
      load_bios_word(14'($urandom) & 14'h3ffc, $urandom);
    end else if (pick < 49) begin
      issue(OP_LOAD, $urandom, 2'($urandom), $urandom);
    end else if (pick < 80) begin
      if (rom_words.size() != 0 && $urandom_range(2) == 0)
        issue(OP_READ, rom_alias(rom_words[$urandom_range(rom_words.size() - 1)]),
              2'($urandom), $urandom);
      else if (ram_words.size() != 0)
        issue(OP_READ, alias_of(ram_words[$urandom_range(ram_words.size() - 1)]),
              2'($urandom), $urandom);
      else
        issue(OP_READ, quiet_address(), 2'($urandom), $urandom);
    end else if (pick < 90) begin
      issue($urandom_range(1) ? OP_WRITE : OP_READ, {4'($urandom), RGN_IO, 24'($urandom)},
            2'($urandom), $urandom);
    end else if (pick < 96) begin
      issue(OP_READ, quiet_address(), 2'($urandom), $urandom);
    end else begin
      issue(OP_NOP, $urandom, 2'($urandom), $urandom);
    end
  endtask

  // stop sending, let every result drain, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup cycle then access cycle; the register takes the value at the end of the access cycle
  task automatic write_rom_mask(input logic [24:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ROM_MASK_ADDR;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    rom_window = value;
    // old rom words may sit outside the new window
    rom_words.delete();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        case (p)
          1:       write_rom_mask(ROM_MASK_RESET);   // widest window
          2:       write_rom_mask('0);               // every rom read hits word zero
          default: write_rom_mask(25'($urandom));
        endcase
      end
      // phase back-pressure: none, sender idle, receiver stall, both, none, both
      case (p)
        1: begin
          send_idle = 67;
          stall_pct <= 0;
        end
        2: begin
          send_idle = 0;
          stall_pct <= 67;
        end
        3, 5: begin
          send_idle = 30;
          stall_pct <= 30;
        end
        default: begin
          send_idle = 0;
          stall_pct <= 0;
        end
      endcase
      phase_items = 0;

      if (p == 0) begin
        // slow ram extremes of data, read back through a mirror
        issue(OP_WRITE, 32'h0200_0000, SZ_WORD, 32'hffff_ffff);
        issue(OP_READ, 32'hf23c_0000, SZ_WORD, 32'h0000_0000);
        // top word of fast ram, wide size code acts as word
        issue(OP_WRITE, 32'h0300_7ffc, SZ_WIDE, 32'h0000_0000);
        issue(OP_READ, 32'h0300_7fff, SZ_BYTE, 32'hffff_ffff);
        // byte write to palette lands in both bytes of its halfword
        issue(OP_WRITE, 32'h0500_03fc, SZ_WORD, 32'h1234_5678);
        issue(OP_WRITE, 32'h0500_03ff, SZ_BYTE, 32'hffff_ffa5);
        issue(OP_READ, 32'h0500_03fc, SZ_WORD, 32'h0000_0000);
        // last video ram word, byte duplication, then the hole above it
        issue(OP_WRITE, 32'h0601_7ffc, SZ_WORD, 32'h8765_4321);
        issue(OP_WRITE, 32'h0601_7ffc, SZ_BYTE, 32'h0000_005a);
        issue(OP_READ, 32'h0601_7ffc, SZ_WORD, 32'h0000_0000);
        issue(OP_WRITE, 32'h0601_8000, SZ_WORD, 32'hcafe_f00d);
        issue(OP_READ, 32'h0601_fffc, SZ_WORD, 32'h0000_0000);
        // object ram byte duplication
        issue(OP_WRITE, 32'h0700_0000, SZ_WORD, 32'h0bad_cafe);
        issue(OP_WRITE, 32'h0700_0001, SZ_BYTE, 32'h0000_0077);
        issue(OP_READ, 32'h0700_0000, SZ_WORD, 32'h0000_0000);
        // bios image load at the top, write ignored, read back
        for (int i = 0; i < 4; i++)
          issue(OP_LOAD, 32'h0000_3ffc + i, SZ_BYTE, 32'hffff_ff00 | (32'h11 * (i + 1)));
        issue(OP_WRITE, 32'h0000_3ffc, SZ_WORD, 32'h0000_0000);
        issue(OP_READ, 32'h0000_3ffc, SZ_WORD, 32'h0000_0000);
        // rom image load at the top of the window, read from two rom regions
        for (int i = 0; i < 4; i++)
          issue(OP_LOAD, 32'h09ff_fffc + i, SZ_WIDE, 32'h0000_00c0 + i);
        issue(OP_READ, 32'h09ff_fffc, SZ_WORD, 32'h0000_0000);
        issue(OP_READ, 32'h0dff_fffd, SZ_BYTE, 32'h0000_0000);
        // forwarded i/o accesses
        issue(OP_READ, 32'h0400_0003, SZ_HALF, 32'hffff_ffff);
        issue(OP_WRITE, 32'hf400_0007, SZ_WIDE, 32'hdead_beef);
        // silent regions, no-op opcode, load to a region that takes none
        issue(OP_READ, 32'h0100_0000, SZ_WORD, 32'h0000_0000);
        issue(OP_READ, 32'hffff_ffff, SZ_WIDE, 32'h0000_0000);
        issue(OP_NOP, 32'h0200_0000, SZ_WORD, 32'hffff_ffff);
        issue(OP_LOAD, 32'h0200_0000, SZ_WORD, 32'h0000_0000);
        issue(OP_READ, 32'h0200_0000, SZ_WORD, 32'h0000_0000);
      end

      while (phase_items < PHASE_ITEMS) random_item();
    end

    wait_idle();
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule : tb_top
